[src/rzc_pkg.sv]
// Shared constants and types for the z-axis cylinder intersection pipeline.
// No dependencies.
package rzc_pkg;

  localparam int LIMB_W = 32;

  typedef struct packed {
    logic hit_any;
    logic take_small;
    logic take_large;
    logic b_le0;
  } root_flags_t;

endpackage

[src/ray_zaxis_cylinder_intersect.sv]
// Top level of the ray against z-axis cylinder intersection pipeline.
// Depends on rzc_pkg and rzc_mul.
//
// One ray beat is accepted every clock unless the output stalls, and each
// produces one result beat. Most of the pipeline depth comes from the square
// root, which resolves one result bit per stage over 2*DATA_WIDTH stages, and
// the divider, which resolves one quotient bit per stage over DATA_WIDTH-1
// stages. Backpressure on the output stalls the whole pipeline in place.
module ray_zaxis_cylinder_intersect #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // support_x, support_y, direction_x, direction_y, cylinder_radius
  input  logic [((5*DATA_WIDTH-1+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hit_any, hit_causal, ray_param
  output logic [((DATA_WIDTH+1+7)/8)*8-1:0]   m_axis_tdata
);

  localparam int DW     = DATA_WIDTH;
  localparam int PW     = 2 * DW;
  localparam int BW     = PW + 1;
  localparam int SW     = 4 * DW;
  localparam int QW     = SW + 1;
  localparam int NW     = PW + 1;
  localparam int XW     = 3 * DW + FRAC_BITS + 1;
  localparam int NSQ    = PW;
  localparam int NDV    = DW - 1;
  localparam int OUT_TW = ((DW + 1 + 7) / 8) * 8;

  typedef struct packed {
    logic [PW-1:0] d;
    logic [PW-1:0] mb;
    logic          dz;
    logic          ble0;
    logic          cneg;
    logic          cle0;
  } side_t;

  typedef struct packed {
    logic [PW-1:0]        d;
    logic [PW-1:0]        mb;
    rzc_pkg::root_flags_t fl;
  } sq_side_t;

  typedef struct packed {
    logic [PW-1:0] d;
    logic          hit_any;
    logic          causal;
    logic          sat;
  } dv_side_t;

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Valid bits.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v10_q, ov_q;
  logic sq_v_q [NSQ+1];
  logic dv_v_q [NDV+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v10_q <= 1'b0;
      ov_q  <= 1'b0;
      for (int k = 0; k <= NSQ; k++) sq_v_q[k] <= 1'b0;
      for (int j = 0; j <= NDV; j++) dv_v_q[j] <= 1'b0;
    end else if (adv) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      v7_q      <= v6_q;
      v8_q      <= v7_q;
      sq_v_q[0] <= v8_q;
      for (int k = 0; k < NSQ; k++) sq_v_q[k+1] <= sq_v_q[k];
      v10_q     <= sq_v_q[NSQ];
      dv_v_q[0] <= v10_q;
      for (int j = 0; j < NDV; j++) dv_v_q[j+1] <= dv_v_q[j];
      ov_q      <= dv_v_q[NDV];
    end
  end

  // Input capture and magnitudes.
  logic [DW-1:0] sx1_q, sy1_q, dx1_q, dy1_q;
  logic [DW-2:0] r1_q;
  logic [DW-1:0] msx2_q, msy2_q, mdx2_q, mdy2_q, mr2_q;
  logic [1:0]    sg2_q, sg3_q, sg4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx1_q  <= s_axis_tdata[0*DW +: DW];
      sy1_q  <= s_axis_tdata[1*DW +: DW];
      dx1_q  <= s_axis_tdata[2*DW +: DW];
      dy1_q  <= s_axis_tdata[3*DW +: DW];
      r1_q   <= s_axis_tdata[4*DW +: DW-1];
      msx2_q <= sx1_q[DW-1] ? (~sx1_q + 1'b1) : sx1_q;
      msy2_q <= sy1_q[DW-1] ? (~sy1_q + 1'b1) : sy1_q;
      mdx2_q <= dx1_q[DW-1] ? (~dx1_q + 1'b1) : dx1_q;
      mdy2_q <= dy1_q[DW-1] ? (~dy1_q + 1'b1) : dy1_q;
      mr2_q  <= {1'b0, r1_q};
      sg2_q  <= {sy1_q[DW-1] ^ dy1_q[DW-1], sx1_q[DW-1] ^ dx1_q[DW-1]};
      sg3_q  <= sg2_q;
      sg4_q  <= sg3_q;
    end
  end

  logic [PW-1:0] p_sxdx, p_sydy, p_dxdx, p_dydy, p_sxsx, p_sysy, p_rr;

  rzc_mul #(.W(DW)) u_mul_sxdx (.clk_i, .en_i(adv), .a_i(msx2_q), .b_i(mdx2_q), .p_o(p_sxdx));
  rzc_mul #(.W(DW)) u_mul_sydy (.clk_i, .en_i(adv), .a_i(msy2_q), .b_i(mdy2_q), .p_o(p_sydy));
  rzc_mul #(.W(DW)) u_mul_dxdx (.clk_i, .en_i(adv), .a_i(mdx2_q), .b_i(mdx2_q), .p_o(p_dxdx));
  rzc_mul #(.W(DW)) u_mul_dydy (.clk_i, .en_i(adv), .a_i(mdy2_q), .b_i(mdy2_q), .p_o(p_dydy));
  rzc_mul #(.W(DW)) u_mul_sxsx (.clk_i, .en_i(adv), .a_i(msx2_q), .b_i(msx2_q), .p_o(p_sxsx));
  rzc_mul #(.W(DW)) u_mul_sysy (.clk_i, .en_i(adv), .a_i(msy2_q), .b_i(msy2_q), .p_o(p_sysy));
  rzc_mul #(.W(DW)) u_mul_rr   (.clk_i, .en_i(adv), .a_i(mr2_q),  .b_i(mr2_q),  .p_o(p_rr));

  // Quadratic coefficients.
  logic [BW-1:0] t1, t2, b5_d, c5_d;
  logic [BW-1:0] b5_q, c5_q;
  logic [PW-1:0] d5_q;
  side_t         s6_d, s6_q, s7_q, s8_q;
  logic [PW-1:0] mc6_q;

  always_comb begin
    t1   = {1'b0, p_sxdx};
    t2   = {1'b0, p_sydy};
    b5_d = (sg4_q[0] ? -t1 : t1) + (sg4_q[1] ? -t2 : t2);
    c5_d = {1'b0, p_sxsx} + {1'b0, p_sysy} - {1'b0, p_rr};
  end

  always_comb begin
    s6_d.d    = d5_q;
    s6_d.mb   = b5_q[BW-1] ? PW'(-b5_q) : b5_q[PW-1:0];
    s6_d.dz   = (d5_q == '0);
    s6_d.ble0 = b5_q[BW-1] || (b5_q == '0);
    s6_d.cneg = c5_q[BW-1];
    s6_d.cle0 = c5_q[BW-1] || (c5_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b5_q  <= b5_d;
      c5_q  <= c5_d;
      d5_q  <= p_dxdx + p_dydy;
      s6_q  <= s6_d;
      mc6_q <= c5_q[BW-1] ? PW'(-c5_q) : c5_q[PW-1:0];
      s7_q  <= s6_q;
      s8_q  <= s7_q;
    end
  end

  logic [SW-1:0] p_bb, p_dc;

  rzc_mul #(.W(PW)) u_mul_bb (.clk_i, .en_i(adv), .a_i(s6_q.mb), .b_i(s6_q.mb), .p_o(p_bb));
  rzc_mul #(.W(PW)) u_mul_dc (.clk_i, .en_i(adv), .a_i(s6_q.d),  .b_i(mc6_q),   .p_o(p_dc));

  // Discriminant and square root.
  logic [QW-1:0] disc;
  sq_side_t      sq9_side;
  logic [SW-1:0] sq_n_q [NSQ+1];
  logic [SW-1:0] sq_r_q [NSQ+1];
  sq_side_t      sq_s_q [NSQ+1];
  logic [SW-1:0] sq_n_d [NSQ];
  logic [SW-1:0] sq_r_d [NSQ];
  logic [SW-1:0] sq_t   [NSQ];
  logic [SW-1:0] sq_b   [NSQ];

  always_comb begin
    disc = s8_q.cneg ? ({1'b0, p_bb} + {1'b0, p_dc}) : ({1'b0, p_bb} - {1'b0, p_dc});
    sq9_side.d             = s8_q.d;
    sq9_side.mb            = s8_q.mb;
    sq9_side.fl.hit_any    = !s8_q.dz && !disc[QW-1];
    sq9_side.fl.take_small = s8_q.ble0 && !s8_q.cneg;
    sq9_side.fl.take_large = s8_q.ble0 || s8_q.cle0;
    sq9_side.fl.b_le0      = s8_q.ble0;
  end

  always_comb begin
    for (int k = 0; k < NSQ; k++) begin
      sq_b[k] = SW'(1) << (SW - 2 - 2*k);
      sq_t[k] = sq_r_q[k] + sq_b[k];
      if (sq_n_q[k] >= sq_t[k]) begin
        sq_n_d[k] = sq_n_q[k] - sq_t[k];
        sq_r_d[k] = (sq_r_q[k] >> 1) + sq_b[k];
      end else begin
        sq_n_d[k] = sq_n_q[k];
        sq_r_d[k] = sq_r_q[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_n_q[0] <= disc[SW-1:0];
      sq_r_q[0] <= '0;
      sq_s_q[0] <= sq9_side;
      for (int k = 0; k < NSQ; k++) begin
        sq_n_q[k+1] <= sq_n_d[k];
        sq_r_q[k+1] <= sq_r_d[k];
        sq_s_q[k+1] <= sq_s_q[k];
      end
    end
  end

  // Root selection, saturation check and division.
  sq_side_t      sl;
  logic [PW-1:0] sroot;
  logic [NW-1:0] num_d, num10_q;
  logic [PW-1:0] d10_q;
  logic          hit10_q, causal10_q;
  logic [XW-1:0] rem0;
  logic [XW-1:0] dv_r_q [NDV+1];
  logic [NDV-1:0] dv_q_q [NDV+1];
  dv_side_t      dv_s_q [NDV+1];
  logic [XW-1:0] dv_k   [NDV];
  logic [XW-1:0] dv_r_d [NDV];
  logic [NDV-1:0] dv_q_d [NDV];

  always_comb begin
    sl    = sq_s_q[NSQ];
    sroot = sq_r_q[NSQ][PW-1:0];
    if (sl.fl.take_small) begin
      num_d = {1'b0, sl.mb} - {1'b0, sroot};
    end else if (sl.fl.b_le0) begin
      num_d = {1'b0, sl.mb} + {1'b0, sroot};
    end else begin
      num_d = {1'b0, sroot} - {1'b0, sl.mb};
    end
    rem0 = XW'(num10_q) << FRAC_BITS;
  end

  always_comb begin
    for (int j = 0; j < NDV; j++) begin
      dv_k[j] = XW'(dv_s_q[j].d) << (NDV - 1 - j);
      if (dv_r_q[j] >= dv_k[j]) begin
        dv_r_d[j] = dv_r_q[j] - dv_k[j];
        dv_q_d[j] = dv_q_q[j] | (NDV'(1) << (NDV - 1 - j));
      end else begin
        dv_r_d[j] = dv_r_q[j];
        dv_q_d[j] = dv_q_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num10_q           <= num_d;
      d10_q             <= sl.d;
      hit10_q           <= sl.fl.hit_any;
      causal10_q        <= sl.fl.hit_any && (sl.fl.take_small || sl.fl.take_large);
      dv_r_q[0]         <= rem0;
      dv_q_q[0]         <= '0;
      dv_s_q[0].d       <= d10_q;
      dv_s_q[0].hit_any <= hit10_q;
      dv_s_q[0].causal  <= causal10_q;
      dv_s_q[0].sat     <= rem0 >= (XW'(d10_q) << (DW - 1));
      for (int j = 0; j < NDV; j++) begin
        dv_r_q[j+1] <= dv_r_d[j];
        dv_q_q[j+1] <= dv_q_d[j];
        dv_s_q[j+1] <= dv_s_q[j];
      end
    end
  end

  // Output register.
  logic [OUT_TW-1:0] out_d, out_q;

  always_comb begin
    out_d    = '0;
    out_d[0] = dv_s_q[NDV].hit_any;
    out_d[1] = dv_s_q[NDV].causal;
    if (!dv_s_q[NDV].causal) begin
      out_d[DW:2] = '0;
    end else if (dv_s_q[NDV].sat) begin
      out_d[DW:2] = '1;
    end else begin
      out_d[DW:2] = dv_q_q[NDV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input stalled while the output register is empty.");

  a_causal_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("Causal hit reported without a hit.");

  a_param_zero_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> (m_axis_tdata[DW:2] == '0))
    else $error("Nonzero ray parameter without a causal hit.");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(dv_v_q[0]) && $stable(sq_v_q[0]))
    else $error("Pipeline moved during a stall.");
`endif

endmodule

[src/rzc_mul.sv]
// Pipelined unsigned multiplier built from registered limb partial products.
// Depends on rzc_pkg for the limb width.
module rzc_mul #(
  parameter int W = 32
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  localparam int L  = rzc_pkg::LIMB_W;
  localparam int N  = (W + L - 1) / L;
  localparam int XW = N * L;

  logic [XW-1:0]    a_x, b_x;
  logic [2*L-1:0]   pp_q [N*N];
  logic [2*XW-1:0]  acc;
  logic [2*W-1:0]   p_q;

  assign a_x = XW'(a_i);
  assign b_x = XW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          pp_q[i*N+j] <= (2*L)'(a_x[i*L +: L]) * (2*L)'(b_x[j*L +: L]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        acc = acc + ((2*XW)'(pp_q[i*N+j]) << (L*(i+j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= acc[2*W-1:0];
    end
  end

  assign p_o = p_q;

endmodule
